### rtl/core/cbq_pkg.sv
// Shared constants, control word and arithmetic helpers of the biquad cascade.
package cbq_pkg;

    localparam int COEF_W          = 24;
    localparam int COEF_FRAC       = 20;
    localparam int DLY_W           = 32;
    localparam int DLY_FRAC        = 12;
    localparam int PROD_W          = COEF_W + DLY_W;
    localparam int ACC_EXT_W       = PROD_W - COEF_FRAC + 1;
    localparam int OUT_EXT_W       = 26;
    localparam int COEFS_PER_STAGE = 5;
    localparam int CFG_W           = 3;
    localparam int IDX_W           = 5;
    localparam int CNT_W           = 4;
    localparam int STEP_W          = 3;
    localparam int SLOT_W          = 3;
    localparam int DEF_MAX_STAGES  = 4;
    localparam int DEF_SAMPLE_BITS = 16;

    // item kinds
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    // coefficient slots within a stage
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    // multiplier operand select
    localparam logic [1:0] MSEL_W1  = 2'd0;
    localparam logic [1:0] MSEL_W2  = 2'd1;
    localparam logic [1:0] MSEL_ACC = 2'd2;

    // accumulator operation
    localparam logic [1:0] AOP_NONE = 2'd0;
    localparam logic [1:0] AOP_SUB  = 2'd1;
    localparam logic [1:0] AOP_LOAD = 2'd2;
    localparam logic [1:0] AOP_ADD  = 2'd3;

    // steps of one stage
    localparam logic [STEP_W-1:0] ST_A1_RD  = 3'd0;
    localparam logic [STEP_W-1:0] ST_A2_RD  = 3'd1;
    localparam logic [STEP_W-1:0] ST_A1_ACC = 3'd2;
    localparam logic [STEP_W-1:0] ST_A2_ACC = 3'd3;
    localparam logic [STEP_W-1:0] ST_B0_MUL = 3'd4;
    localparam logic [STEP_W-1:0] ST_B1_MUL = 3'd5;
    localparam logic [STEP_W-1:0] ST_B2_MUL = 3'd6;
    localparam logic [STEP_W-1:0] ST_Y_DONE = 3'd7;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] slot;
        logic              mul_en;
        logic [1:0]        mul_sel;
        logic [1:0]        acc_op;
        logic              save_w0;
        logic              upd_dly;
        logic              out_load;
    } t_ctrl;

    // Schedule: coefficient read, multiply, accumulate; each result is registered.
    function automatic t_ctrl step_ctrl(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '0;
        case (step)
            ST_A1_RD: begin
                c.rd_en = 1'b1;
                c.slot  = SLOT_A1;
            end
            ST_A2_RD: begin
                c.rd_en   = 1'b1;
                c.slot    = SLOT_A2;
                c.mul_en  = 1'b1;
                c.mul_sel = MSEL_W1;
            end
            ST_A1_ACC: begin
                c.mul_en  = 1'b1;
                c.mul_sel = MSEL_W2;
                c.acc_op  = AOP_SUB;
            end
            ST_A2_ACC: begin
                c.rd_en  = 1'b1;
                c.slot   = SLOT_B0;
                c.acc_op = AOP_SUB;
            end
            ST_B0_MUL: begin
                c.rd_en   = 1'b1;
                c.slot    = SLOT_B1;
                c.mul_en  = 1'b1;
                c.mul_sel = MSEL_ACC;
                c.save_w0 = 1'b1;
            end
            ST_B1_MUL: begin
                c.rd_en   = 1'b1;
                c.slot    = SLOT_B2;
                c.mul_en  = 1'b1;
                c.mul_sel = MSEL_W1;
                c.acc_op  = AOP_LOAD;
            end
            ST_B2_MUL: begin
                c.mul_en  = 1'b1;
                c.mul_sel = MSEL_W2;
                c.acc_op  = AOP_ADD;
            end
            ST_Y_DONE: begin
                c.acc_op  = AOP_ADD;
                c.upd_dly = 1'b1;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Saturate to 32 bits; returns {saturated, value}.
    function automatic logic [DLY_W:0] sat_dly(input logic signed [ACC_EXT_W-1:0] v);
        logic [ACC_EXT_W-DLY_W:0] hi;
        hi = v[ACC_EXT_W-1:DLY_W-1];
        if ((&hi) || !(|hi)) begin
            return {1'b0, v[DLY_W-1:0]};
        end else if (v[ACC_EXT_W-1]) begin
            return {1'b1, 1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(DLY_W-1){1'b1}}};
        end
    endfunction

    // Round half up and drop the coefficient fraction.
    function automatic logic signed [ACC_EXT_W-1:0] round_prod(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(1 << (COEF_FRAC - 1));
        return {t[PROD_W-1], t[PROD_W-1:COEF_FRAC]};
    endfunction

endpackage

### rtl/core/cbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cbq_seq.sv
// Step sequencer: walks the five products of each active stage, then hands off the result.
module cbq_seq #(
    parameter int MAX_STAGES = cbq_pkg::DEF_MAX_STAGES,
    localparam int STG_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
    localparam int ADDR_W    = $clog2(cbq_pkg::COEFS_PER_STAGE * MAX_STAGES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cbq_pkg::CNT_W-1:0]  i_last_stg,
    input  logic                       i_out_free,
    output logic                       o_ready,
    output cbq_pkg::t_ctrl             o_ctrl,
    output logic [STG_W-1:0]           o_stage,
    output logic [ADDR_W-1:0]          o_rd_addr
);
    import cbq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [STG_W-1:0]  r_stage, n_stage;
    logic [ADDR_W-1:0] r_base,  n_base;
    t_ctrl             ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_stage <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_stage <= n_stage;
            r_base  <= n_base;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_stage = r_stage;
        n_base  = r_base;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_step  = '0;
                    n_stage = '0;
                    n_base  = '0;
                end
            end
            S_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == ST_Y_DONE) begin
                    if (CNT_W'(r_stage) == i_last_stg) begin
                        n_state = S_FIN;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_base  = r_base + ADDR_W'(COEFS_PER_STAGE);
                    end
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        if (r_state == S_RUN) begin
            ctrl = step_ctrl(r_step);
        end
        ctrl.out_load = (r_state == S_FIN) && i_out_free;
    end

    assign o_ctrl    = ctrl;
    assign o_ready   = (r_state == S_IDLE);
    assign o_stage   = r_stage;
    assign o_rd_addr = r_base + ADDR_W'(ctrl.slot);

endmodule

### rtl/core/cbq_datapath.sv
// Shared multiply-accumulate with rounding and saturation, plus the per-stage delay lines.
module cbq_datapath #(
    parameter int MAX_STAGES  = cbq_pkg::DEF_MAX_STAGES,
    parameter int SAMPLE_BITS = cbq_pkg::DEF_SAMPLE_BITS,
    localparam int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cbq_pkg::t_ctrl                     i_ctrl,
    input  logic [STG_W-1:0]                   i_stage,
    input  logic                               i_start,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic signed [cbq_pkg::COEF_W-1:0]  i_coef,
    output logic signed [cbq_pkg::DLY_W-1:0]   o_acc,
    output logic                               o_clip
);
    import cbq_pkg::*;

    logic signed [DLY_W-1:0]     r_acc, n_acc;
    logic                        r_clip, n_clip;
    logic signed [DLY_W-1:0]     r_w0;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [DLY_W-1:0]     r_d1 [MAX_STAGES];
    logic signed [DLY_W-1:0]     r_d2 [MAX_STAGES];

    logic signed [DLY_W-1:0]     w1, w2, w_op;
    logic signed [ACC_EXT_W-1:0] in_x, acc_x, prd_x, sum_x;
    logic [DLY_W:0]              in_s, prd_s, sum_s;
    logic signed [DLY_W-1:0]     prd_v;

    assign w1 = r_d1[i_stage];
    assign w2 = r_d2[i_stage];

    always_comb begin
        case (i_ctrl.mul_sel)
            MSEL_W1:  w_op = w1;
            MSEL_W2:  w_op = w2;
            MSEL_ACC: w_op = r_acc;
            default:  w_op = w1;
        endcase
    end

    // sample enters as Q19.12
    assign in_x  = ACC_EXT_W'(i_sample) <<< DLY_FRAC;
    assign in_s  = sat_dly(in_x);

    assign prd_s = sat_dly(round_prod(r_prod));
    assign prd_v = prd_s[DLY_W-1:0];
    assign acc_x = ACC_EXT_W'(r_acc);
    assign prd_x = ACC_EXT_W'(prd_v);
    assign sum_x = (i_ctrl.acc_op == AOP_SUB) ? (acc_x - prd_x) : (acc_x + prd_x);
    assign sum_s = sat_dly(sum_x);

    always_comb begin
        n_acc  = r_acc;
        n_clip = r_clip;
        if (i_start) begin
            n_acc  = in_s[DLY_W-1:0];
            n_clip = in_s[DLY_W];
        end else begin
            case (i_ctrl.acc_op)
                AOP_SUB, AOP_ADD: begin
                    n_acc  = sum_s[DLY_W-1:0];
                    n_clip = r_clip | prd_s[DLY_W] | sum_s[DLY_W];
                end
                AOP_LOAD: begin
                    n_acc  = prd_v;
                    n_clip = r_clip | prd_s[DLY_W];
                end
                default: begin
                    n_acc  = r_acc;
                    n_clip = r_clip;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else begin
            r_acc  <= n_acc;
            r_clip <= n_clip;
            if (i_ctrl.upd_dly) begin
                r_d2[i_stage] <= r_d1[i_stage];
                r_d1[i_stage] <= r_w0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * w_op;
        end
        if (i_ctrl.save_w0) begin
            r_w0 <= r_acc;
        end
    end

    assign o_acc  = r_acc;
    assign o_clip = r_clip;

endmodule

### rtl/core/cascaded_biquad_iir_filter_top.sv
// Cascaded Direct Form II biquad filter on one shared multiply-accumulate unit.
// A sample runs through the steps of every active stage on the single multiplier, then is
// handed off into the output register; no new item is taken until that handoff is done.
// A finished sample waits in the accumulator while the output register is still held.
// Synchronous active-low reset: one stage in use, delay lines and coefficients zero.
module cascaded_biquad_iir_filter_top #(
    parameter int MAX_STAGES  = cbq_pkg::DEF_MAX_STAGES,
    parameter int SAMPLE_BITS = cbq_pkg::DEF_SAMPLE_BITS,
    localparam int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
    localparam int COEF_DEPTH = cbq_pkg::COEFS_PER_STAGE * MAX_STAGES,
    localparam int ADDR_W     = $clog2(COEF_DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [cbq_pkg::IDX_W-1:0]         i_coeff_index,
    input  logic signed [cbq_pkg::COEF_W-1:0] i_coeff_value,
    input  logic                              i_last_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_filtered,
    output logic                              o_last_out,
    output logic                              o_clipped,
    input  logic                              i_cfg_we,
    input  logic [cbq_pkg::CFG_W-1:0]         i_cfg_data
);
    import cbq_pkg::*;

    localparam logic signed [OUT_EXT_W-1:0] O_MAX = OUT_EXT_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [OUT_EXT_W-1:0] O_MIN = -O_MAX - 1;

    logic [CFG_W-1:0]        r_stages;
    logic [CNT_W-1:0]        stg_cnt, last_stg;
    logic                    in_acc, smp_start, cwr, idx_ok;
    logic [IDX_W:0]          idx_ext;
    logic [ADDR_W-1:0]       waddr, rd_addr;
    logic [COEF_W-1:0]       ram_rdata;
    logic [COEF_DEPTH-1:0]   r_cvld;
    logic                    r_rd_vld;
    logic signed [COEF_W-1:0] coef;
    t_ctrl                   ctrl;
    logic [STG_W-1:0]        stage;
    logic                    out_free;
    logic signed [DLY_W-1:0] acc;
    logic                    clip;
    logic                    r_last;

    logic signed [DLY_W:0]          y_rnd;
    logic signed [DLY_W-DLY_FRAC:0] y_q;
    logic signed [OUT_EXT_W-1:0]    y_ext;
    logic [SAMPLE_BITS-1:0]         y_out;
    logic                           y_sat;

    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_filtered;
    logic                           r_last_out;
    logic                           r_clipped;

    // stage count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_stages <= i_cfg_data;
        end
    end

    always_comb begin
        stg_cnt = (r_stages == '0) ? CNT_W'(1) : CNT_W'(r_stages);
        if (stg_cnt > CNT_W'(MAX_STAGES)) begin
            stg_cnt = CNT_W'(MAX_STAGES);
        end
        last_stg = stg_cnt - 1'b1;
    end

    assign in_acc    = i_in_valid & o_in_ready;
    assign smp_start = in_acc & (i_action == ACT_FILTER);
    assign idx_ext   = (IDX_W + 1)'(i_coeff_index);
    assign idx_ok    = idx_ext < (IDX_W + 1)'(COEF_DEPTH);
    assign cwr       = in_acc & (i_action == ACT_WRITE) & idx_ok;
    assign waddr     = idx_ext[ADDR_W-1:0];

    cbq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (cwr),
        .i_waddr (waddr),
        .i_wdata (i_coeff_value),
        .i_re    (ctrl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // unwritten coefficients read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (cwr) begin
                r_cvld[waddr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                r_rd_vld <= r_cvld[rd_addr];
            end
        end
    end

    assign coef = r_rd_vld ? signed'(ram_rdata) : '0;

    cbq_seq #(
        .MAX_STAGES (MAX_STAGES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (smp_start),
        .i_last_stg (last_stg),
        .i_out_free (out_free),
        .o_ready    (o_in_ready),
        .o_ctrl     (ctrl),
        .o_stage    (stage),
        .o_rd_addr  (rd_addr)
    );

    cbq_datapath #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_stage  (stage),
        .i_start  (smp_start),
        .i_sample (i_sample),
        .i_coef   (coef),
        .o_acc    (acc),
        .o_clip   (clip)
    );

    always_ff @(posedge i_clk) begin
        if (smp_start) begin
            r_last <= i_last_sample;
        end
    end

    // output rounding to whole samples
    assign y_rnd = (DLY_W + 1)'(acc) + (DLY_W + 1)'(1 << (DLY_FRAC - 1));
    assign y_q   = y_rnd[DLY_W:DLY_FRAC];
    assign y_ext = OUT_EXT_W'(y_q);

    always_comb begin
        y_sat = 1'b0;
        y_out = y_ext[SAMPLE_BITS-1:0];
        if (y_ext > O_MAX) begin
            y_sat = 1'b1;
            y_out = O_MAX[SAMPLE_BITS-1:0];
        end else if (y_ext < O_MIN) begin
            y_sat = 1'b1;
            y_out = O_MIN[SAMPLE_BITS-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_filtered <= y_out;
            r_last_out <= r_last;
            r_clipped  <= clip | y_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_last_out  = r_last_out;
    assign o_clipped   = r_clipped;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transaction");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.out_load))
        else $error("result valid without a finished sample");

    a_rd_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.rd_en |-> (rd_addr < ADDR_W'(COEF_DEPTH)))
        else $error("coefficient read beyond store");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.mul_en || ctrl.acc_op != AOP_NONE) |-> !o_in_ready)
        else $error("input ready while a sample is in progress");

endmodule
